>>> src/asus_pkg.sv
package asus_pkg;

  // codec_mode register codes
  localparam logic CODEC_H264 = 1'b0;
  localparam logic CODEC_H265 = 1'b1;

  // NAL header fields
  localparam logic [7:0] H264_TYPE_MASK = 8'h1F;
  localparam logic [7:0] H265_TYPE_MASK = 8'h7E;

  localparam logic [5:0] H264_NAL_SLICE = 6'd1;
  localparam logic [5:0] H264_NAL_IDR   = 6'd5;

  localparam logic [5:0] H265_NAL_TRAIL_N  = 6'd0;
  localparam logic [5:0] H265_NAL_TRAIL_R  = 6'd1;
  localparam logic [5:0] H265_NAL_RASL_N   = 6'd8;
  localparam logic [5:0] H265_NAL_RASL_R   = 6'd9;
  localparam logic [5:0] H265_NAL_IDR_W    = 6'd19;
  localparam logic [5:0] H265_NAL_CRA      = 6'd21;

  localparam logic [7:0] START_CODE_END = 8'h01;
  localparam logic [7:0] ZERO_BYTE      = 8'h00;

  // depth of the queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic closes;   // picture NAL, frame ends with it
    logic key;      // IDR (H.264) or IDR_W_RADL / CRA (H.265) picture
  } nal_class_t;

  function automatic nal_class_t classify_nal(input logic [7:0] hdr, input logic mode);
    nal_class_t c;
    logic [7:0] m;
    logic [5:0] t;
    if (mode == CODEC_H265) begin
      m = hdr & H265_TYPE_MASK;
      t = m[6:1];
      c.key    = (t == H265_NAL_IDR_W) || (t == H265_NAL_CRA);
      c.closes = (t == H265_NAL_TRAIL_N) || (t == H265_NAL_TRAIL_R) ||
                 (t == H265_NAL_RASL_N) || (t == H265_NAL_RASL_R) || c.key;
    end else begin
      m = hdr & H264_TYPE_MASK;
      t = {1'b0, m[4:0]};
      c.key    = (t == H264_NAL_IDR);
      c.closes = (t == H264_NAL_SLICE) || c.key;
    end
    return c;
  endfunction

endpackage

>>> src/annexb_access_unit_splitter_top.sv
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready   | tdata[7:0] data_byte, tlast end_of_stream
// out_    | out | out_tvalid/out_tready | tdata[31:0] offset, [63:32] length, tuser key
// cfg_    | in  | cfg_wr_en            | cfg_wr_data codec_mode
//
// One byte per clock is accepted while in_tready is high; the parser has no internal loop.
// A frame result is written into the result queue on its closing beat and is then loaded into the output register.
// Four-entry result queue sits between parser and output register; in_tready
// drops only while that queue is full.
// rst_n is synchronous; all stream state returns to offset zero, codec_mode to H.264.
module annexb_access_unit_splitter_top #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] data_byte
  input  logic        in_tlast,     // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,    // [31:0] frame_offset, [63:32] frame_length
  output logic        out_tuser,    // frame_is_key
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_wr_data   // codec_mode
);
  import asus_pkg::*;

  localparam int ENTRY_W = 2 * OFFSET_BITS + 1;

  logic               codec_mode_r;
  logic               beat;
  logic               push, pop, not_empty, full;
  logic [ENTRY_W-1:0] push_data, head_data;
  logic [31:0]        frame_offset, frame_length;
  logic               frame_is_key;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_mode_r <= CODEC_H264;
    end else if (cfg_wr_en) begin
      codec_mode_r <= cfg_wr_data[0];
    end
  end

  assign in_tready = !full;
  assign beat      = in_tvalid && in_tready;

  asus_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .codec_mode    (codec_mode_r),
    .beat          (beat),
    .data_byte     (in_tdata),
    .end_of_stream (in_tlast),
    .push          (push),
    .push_data     (push_data)
  );

  asus_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .not_empty (not_empty),
    .full      (full)
  );

  asus_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_data    (head_data),
    .not_empty    (not_empty),
    .pop          (pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .frame_offset (frame_offset),
    .frame_length (frame_length),
    .frame_is_key (frame_is_key)
  );

  assign out_tdata = {frame_length, frame_offset};
  assign out_tuser = frame_is_key;

endmodule

>>> src/asus_front.sv
module asus_front #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     codec_mode,
  input  logic                     beat,
  input  logic [7:0]               data_byte,
  input  logic                     end_of_stream,
  output logic                     push,
  output logic [2*OFFSET_BITS:0]   push_data    // {key, end_pos, start_pos}
);
  import asus_pkg::*;

  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [1:0]             zrun_r, zrun_nxt;
  logic                   seen_r, seen_nxt;
  logic                   hdr_pend_r, hdr_pend_nxt;
  logic                   closes_r, closes_nxt;
  logic                   key_r, key_nxt;

  nal_class_t             cls;
  logic                   cur_closes, cur_key;
  logic                   is_code;
  logic [OFFSET_BITS-1:0] code_start, pos_inc, end_pos;
  logic                   emit_code, emit_last;

  always_comb begin
    cls        = classify_nal(data_byte, codec_mode);
    cur_closes = hdr_pend_r ? cls.closes : closes_r;
    cur_key    = hdr_pend_r ? cls.key    : key_r;
    is_code    = (data_byte == START_CODE_END) && zrun_r[1];
    // three zeros or more: 4-byte code begins three bytes back
    code_start = pos_r - ((zrun_r == 2'd3) ? OFFSET_BITS'(3) : OFFSET_BITS'(2));
    pos_inc    = pos_r + OFFSET_BITS'(1);
    emit_code  = is_code && seen_r && cur_closes;
    emit_last  = end_of_stream && !is_code && seen_r && cur_closes;
    end_pos    = is_code ? code_start : pos_inc;

    push      = beat && (emit_code || emit_last);
    push_data = {cur_key, end_pos, start_r};

    pos_nxt      = pos_inc;
    start_nxt    = start_r;
    seen_nxt     = seen_r;
    hdr_pend_nxt = 1'b0;
    closes_nxt   = cur_closes;
    key_nxt      = cur_key;
    zrun_nxt     = zrun_r;
    if (is_code) begin
      if (!seen_r || cur_closes) begin
        start_nxt = code_start;
      end
      seen_nxt     = 1'b1;
      closes_nxt   = 1'b0;
      key_nxt      = 1'b0;
      hdr_pend_nxt = 1'b1;
      zrun_nxt     = 2'd0;
    end else if (data_byte == ZERO_BYTE) begin
      if (zrun_r != 2'd3) begin
        zrun_nxt = zrun_r + 2'd1;
      end
    end else begin
      zrun_nxt = 2'd0;
    end
    if (end_of_stream) begin
      pos_nxt      = '0;
      start_nxt    = '0;
      seen_nxt     = 1'b0;
      hdr_pend_nxt = 1'b0;
      closes_nxt   = 1'b0;
      key_nxt      = 1'b0;
      zrun_nxt     = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      start_r    <= '0;
      zrun_r     <= 2'd0;
      seen_r     <= 1'b0;
      hdr_pend_r <= 1'b0;
      closes_r   <= 1'b0;
      key_r      <= 1'b0;
    end else if (beat) begin
      pos_r      <= pos_nxt;
      start_r    <= start_nxt;
      zrun_r     <= zrun_nxt;
      seen_r     <= seen_nxt;
      hdr_pend_r <= hdr_pend_nxt;
      closes_r   <= closes_nxt;
      key_r      <= key_nxt;
    end
  end

endmodule

>>> src/asus_fifo.sv
module asus_fifo #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             not_empty,
  output logic             full
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/asus_back.sv
module asus_back #(
  parameter int OFFSET_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [2*OFFSET_BITS:0] head_data,   // {key, end_pos, start_pos}
  input  logic                   not_empty,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [31:0]            frame_offset,
  output logic [31:0]            frame_length,
  output logic                   frame_is_key
);
  logic [OFFSET_BITS-1:0] start_pos, end_pos, len;
  logic [OFFSET_BITS+31:0] off_ext, len_ext;
  logic                   valid_r;
  logic [31:0]            offset_r, length_r;
  logic                   key_r;

  always_comb begin
    start_pos = head_data[OFFSET_BITS-1:0];
    end_pos   = head_data[2*OFFSET_BITS-1:OFFSET_BITS];
    len       = end_pos - start_pos;   // wraps with the offset counter
    off_ext   = {32'd0, start_pos};
    len_ext   = {32'd0, len};
    pop       = not_empty && (!valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      offset_r <= off_ext[31:0];
      length_r <= len_ext[31:0];
      key_r    <= head_data[2*OFFSET_BITS];
    end
  end

  assign out_valid    = valid_r;
  assign frame_offset = offset_r;
  assign frame_length = length_r;
  assign frame_is_key = key_r;

endmodule
